// ===== rtl/mms_pkg.sv =====
package mms_pkg;

    // Default sizes of the array and its operands.
    localparam int DEF_MAX_INNER     = 64;
    localparam int DEF_MAX_COLUMNS   = 16;
    localparam int DEF_OPERAND_WIDTH = 16;

    // Fixed field widths of the request and result channels.
    localparam int ACC_W       = 40;
    localparam int ROW_W       = 16;
    localparam int INNER_IDX_W = 6;
    localparam int COL_IDX_W   = 4;
    localparam int INNER_LEN_W = 7;
    localparam int COL_CNT_W   = 5;
    localparam int CFG_DATA_W  = 8;

    // Request kinds.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_STREAM = 1'b1;

    // Configuration register indexes.
    typedef enum logic {
        CFG_INNER_LENGTH = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } cfg_index_t;

    // Register values after reset.
    localparam logic [INNER_LEN_W-1:0] INNER_LENGTH_RESET = INNER_LEN_W'(64);
    localparam logic [COL_CNT_W-1:0]   COLUMN_COUNT_RESET = COL_CNT_W'(16);

    // Control shared by every cell of the row.
    typedef struct packed {
        logic advance;  // pipeline moves this cycle
        logic mac;      // a stream element sits in the product stage
        logic row_end;  // that element closes its row
        logic shift;    // result chain moves one place toward the output
    } cell_ctrl_t;

endpackage

// ===== rtl/mms_ram.sv =====
module mms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mms_cell.sv =====
module mms_cell import mms_pkg::*; #(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH,
    parameter int MAX_INNER     = DEF_MAX_INNER
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cell_ctrl_t                      ctrl,
    input  logic                            active,
    input  logic                            wr_en,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] wr_addr,
    input  logic [OPERAND_WIDTH-1:0]        wr_data,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] rd_addr,
    input  logic signed [OPERAND_WIDTH-1:0] a_operand,
    input  logic signed [ACC_W-1:0]         res_in,
    output logic signed [ACC_W-1:0]         res_out
);

    logic [OPERAND_WIDTH-1:0]         weight;
    logic signed [2*OPERAND_WIDTH-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]          acc_reg, acc_next;
    logic signed [ACC_W-1:0]          res_reg, res_next;
    logic signed [ACC_W-1:0]          prod_ext;
    logic signed [ACC_W-1:0]          sum;

    // This cell's column of B, one word per inner position.
    mms_ram #(
        .WIDTH(OPERAND_WIDTH),
        .DEPTH(MAX_INNER)
    ) u_weights (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (ctrl.advance),
        .rd_addr(rd_addr),
        .rd_data(weight)
    );

    // Product of the streamed element and the weight, registered.
    always_comb begin
        prod_next = prod_reg;
        if (ctrl.advance) begin
            prod_next = a_operand * $signed(weight);
        end
    end

    // The product is sign extended or wrapped to the accumulator width.
    assign prod_ext = ACC_W'(prod_reg);
    assign sum      = acc_reg + prod_ext;

    // Running sum; cleared when the row closes, held for unused columns.
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.advance && ctrl.mac) begin
            if (ctrl.row_end) begin
                acc_next = '0;
            end else if (active) begin
                acc_next = sum;
            end
        end
    end

    // Result chain: captures the final sum, then shifts toward the output.
    always_comb begin
        res_next = res_reg;
        if (ctrl.advance && ctrl.mac && ctrl.row_end) begin
            res_next = sum;
        end else if (ctrl.shift) begin
            res_next = res_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res_out = res_reg;

endmodule

// ===== rtl/matrix_multiply_stream_top.sv =====
// Streaming matrix multiply C = A x B in fixed point.
// Requests on the s_ channel either load one B element (s_req_type = 0) into
// the weight column of cell s_column_index at row s_inner_index, or stream one
// A element (s_req_type = 1) in row order. Each stream request is multiplied
// by the weights of its inner position in all cells at once and added to the
// 40-bit accumulator of each cell in use.
// The request that closes a row copies the sums into a result chain, and the
// m_ channel then presents that row's N results, columns 0 to N-1, with
// m_out_last on the final one. The closing request passes the operand and
// product stages and then loads the chain; the chain drains one result per
// accepted transfer.
// Requests are taken one per cycle while s_ready is high. A row-closing
// request stalls in the product stage while the previous row is still
// draining, so when the receiver stalls the pipeline stalls behind it; rows
// of K >= N + 1 sustain one request per cycle with an always-ready receiver.
// The cfg_ channel writes inner_length (index 0) and column_count (index 1);
// write it only while the block is idle.
// Reset clears the accumulators and position, row and result counters, not
// the chain. Weights are undefined until loaded; no clearing pass is run.
module matrix_multiply_stream_top import mms_pkg::*; #(
    parameter int MAX_INNER     = DEF_MAX_INNER,
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration writes.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // Requests.
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic [INNER_IDX_W-1:0]   s_inner_index,
    input  logic [COL_IDX_W-1:0]     s_column_index,
    input  logic signed [OPERAND_WIDTH-1:0] s_value,
    // Results.
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ROW_W-1:0]         m_out_row,
    output logic [COL_IDX_W-1:0]     m_out_column,
    output logic signed [ACC_W-1:0]  m_out_value,
    output logic                     m_out_last
);

    localparam int PW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int KCW = ($clog2(MAX_INNER + 1) > INNER_LEN_W) ?
                         $clog2(MAX_INNER + 1) : INNER_LEN_W;
    localparam int NCW = ($clog2(MAX_COLUMNS + 1) > COL_CNT_W) ?
                         $clog2(MAX_COLUMNS + 1) : COL_CNT_W;

    logic [INNER_LEN_W-1:0] inner_length_reg, inner_length_next;
    logic [COL_CNT_W-1:0]   column_count_reg, column_count_next;
    logic [KCW-1:0]         k_eff;
    logic [NCW-1:0]         n_eff;

    logic                   advance;
    logic                   accept;
    logic                   stream_accept;
    logic                   load_ok;
    logic                   row_end;
    logic                   chain_load;
    logic                   pop;

    logic [PW-1:0]          pos_reg, pos_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_end_reg, s1_end_next;
    logic signed [OPERAND_WIDTH-1:0] a_s1_reg, a_s1_next;
    logic                   s2_valid_reg, s2_valid_next;
    logic                   s2_end_reg, s2_end_next;

    logic [ROW_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [ROW_W-1:0]       out_row_reg, out_row_next;
    logic [NCW-1:0]         rem_reg, rem_next;
    logic [CW-1:0]          col_reg, col_next;
    logic                   busy;

    cell_ctrl_t             ctrl;
    logic signed [ACC_W-1:0] res_chain [MAX_COLUMNS+1];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb begin
        inner_length_next = inner_length_reg;
        column_count_next = column_count_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INNER_LENGTH: inner_length_next = cfg_data[INNER_LEN_W-1:0];
                CFG_COLUMN_COUNT: column_count_next = cfg_data[COL_CNT_W-1:0];
            endcase
        end
    end

    // Effective K and N, limited to the range the array supports.
    always_comb begin
        priority if (inner_length_reg == '0) begin
            k_eff = KCW'(1);
        end else if (KCW'(inner_length_reg) > KCW'(MAX_INNER)) begin
            k_eff = KCW'(MAX_INNER);
        end else begin
            k_eff = KCW'(inner_length_reg);
        end
    end

    always_comb begin
        priority if (column_count_reg == '0) begin
            n_eff = NCW'(1);
        end else if (NCW'(column_count_reg) > NCW'(MAX_COLUMNS)) begin
            n_eff = NCW'(MAX_COLUMNS);
        end else begin
            n_eff = NCW'(column_count_reg);
        end
    end

    // The pipeline holds only while a closing row waits for the result chain.
    assign busy          = (rem_reg != '0);
    assign advance       = !(s2_valid_reg && s2_end_reg && busy);
    assign s_ready       = advance;
    assign accept        = s_valid && s_ready;
    assign stream_accept = accept && (s_req_type == REQ_STREAM);
    assign load_ok       = accept && (s_req_type == REQ_LOAD) &&
                           (int'(s_inner_index) < MAX_INNER);
    assign row_end       = ((KCW'(pos_reg) + KCW'(1)) >= k_eff);
    assign chain_load    = advance && s2_valid_reg && s2_end_reg;
    assign pop           = m_valid && m_ready;

    // Position within the row and the two pipeline stages.
    always_comb begin
        pos_next      = pos_reg;
        s1_valid_next = s1_valid_reg;
        s1_end_next   = s1_end_reg;
        a_s1_next     = a_s1_reg;
        s2_valid_next = s2_valid_reg;
        s2_end_next   = s2_end_reg;
        if (advance) begin
            s1_valid_next = stream_accept;
            s1_end_next   = row_end;
            a_s1_next     = s_value;
            s2_valid_next = s1_valid_reg;
            s2_end_next   = s1_end_reg;
            if (stream_accept) begin
                pos_next = row_end ? '0 : PW'(pos_reg + PW'(1));
            end
        end
    end

    // Row number and result chain bookkeeping.
    always_comb begin
        row_cnt_next = row_cnt_reg;
        out_row_next = out_row_reg;
        rem_next     = rem_reg;
        col_next     = col_reg;
        if (chain_load) begin
            row_cnt_next = row_cnt_reg + ROW_W'(1);
            out_row_next = row_cnt_reg;
            rem_next     = n_eff;
            col_next     = '0;
        end else if (pop) begin
            rem_next = rem_reg - NCW'(1);
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_length_reg <= INNER_LENGTH_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
            pos_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            row_cnt_reg      <= '0;
            rem_reg          <= '0;
            col_reg          <= '0;
        end else begin
            inner_length_reg <= inner_length_next;
            column_count_reg <= column_count_next;
            pos_reg          <= pos_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            row_cnt_reg      <= row_cnt_next;
            rem_reg          <= rem_next;
            col_reg          <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_end_reg  <= s1_end_next;
        a_s1_reg    <= a_s1_next;
        s2_end_reg  <= s2_end_next;
        out_row_reg <= out_row_next;
    end

    // Control shared by the cells.
    assign ctrl.advance = advance;
    assign ctrl.mac     = s2_valid_reg;
    assign ctrl.row_end = s2_end_reg;
    assign ctrl.shift   = pop;

    // Row of cells, one per result column; results shift toward cell 0.
    assign res_chain[MAX_COLUMNS] = '0;

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
        mms_cell #(
            .OPERAND_WIDTH(OPERAND_WIDTH),
            .MAX_INNER    (MAX_INNER)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .active   (c < int'(n_eff)),
            .wr_en    (load_ok && (int'(s_column_index) == c)),
            .wr_addr  (PW'(s_inner_index)),
            .wr_data  (s_value),
            .rd_addr  (pos_reg),
            .a_operand(a_s1_reg),
            .res_in   (res_chain[c+1]),
            .res_out  (res_chain[c])
        );
    end

    // Result port.
    assign m_valid      = busy;
    assign m_out_row    = out_row_reg;
    assign m_out_column = COL_IDX_W'(col_reg);
    assign m_out_value  = res_chain[0];
    assign m_out_last   = (rem_reg == NCW'(1));

    // Requests stall only behind a closing row that waits for the chain.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s2_valid_reg && s2_end_reg && m_valid))
        else $error("request stall without a waiting row");

    // A closing row starts its results at column 0 in the next cycle.
    a_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_load |=> (m_valid && m_out_column == '0))
        else $error("row results did not start at column 0");

    // The last result of a row empties the chain.
    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_out_last) |=> !m_valid)
        else $error("results remain after the last column");

    // Never more pending results than columns in use.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= n_eff)
        else $error("result count exceeds column count");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mms_pkg::*;

    // Cycles without any accepted transfer before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles allowed for an in-flight stream request to settle before a register write.
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 80;
    localparam int PLAN_LEN       = 28;
    // Inner positions whose weights are loaded up front; no row runs longer.
    localparam int LOADED_INNER   = 4;

    typedef enum logic {
        PLAN_WRITE   = 1'b0,
        PLAN_REQUEST = 1'b1
    } plan_op_t;

    // One row of the directed table: a register write or a request.
    typedef struct packed {
        plan_op_t                op;
        cfg_index_t              reg_sel;
        logic [CFG_DATA_W-1:0]   reg_data;
        logic                    req_type;
        logic [INNER_IDX_W-1:0]  inner_idx;
        logic [COL_IDX_W-1:0]    col_idx;
        logic signed [15:0]      operand;
        logic                    sum_given;
        logic signed [ACC_W-1:0] given_sum;
    } plan_step_t;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [COL_IDX_W-1:0]    out_column;
        logic signed [ACC_W-1:0] out_value;
        logic                    out_last;
    } row_result_t;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    cfg_index_t                    cfg_index      = CFG_INNER_LENGTH;
    logic [CFG_DATA_W-1:0]         cfg_data       = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_req_type     = REQ_LOAD;
    logic [INNER_IDX_W-1:0]        s_inner_index  = '0;
    logic [COL_IDX_W-1:0]          s_column_index = '0;
    logic signed [15:0]            s_value        = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [ROW_W-1:0]              m_out_row;
    logic [COL_IDX_W-1:0]          m_out_column;
    logic signed [ACC_W-1:0]       m_out_value;
    logic                          m_out_last;

    // Shadow copy of the block: registers, weights, running sums and counters.
    logic [INNER_LEN_W-1:0]  inner_len_copy = INNER_LENGTH_RESET;
    logic [COL_CNT_W-1:0]    col_count_copy = COLUMN_COUNT_RESET;
    logic signed [15:0]      weight_copy [DEF_MAX_INNER][DEF_MAX_COLUMNS];
    logic signed [ACC_W-1:0] sum_copy [DEF_MAX_COLUMNS];
    int                      position_copy = 0;
    logic [ROW_W-1:0]        row_copy = '0;

    row_result_t pending_results [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          steady_flow = 1'b0;

    // Directed table. Sums are typed in where they are plain products of
    // single-column, single-element rows; all other rows use the shadow model.
    plan_step_t directed_plan [PLAN_LEN] = '{
        '{PLAN_WRITE,   CFG_INNER_LENGTH, 8'h01, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh0800, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_COLUMN_COUNT, 8'h01, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd0,  4'd0,  16'sh1000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh1000, 1'b1,
          40'sd16777216},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd0,  4'd0,  16'sh8000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh8000, 1'b1,
          40'sd1073741824},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh7FFF, 1'b1,
          -40'sd1073709056},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd0,  4'd0,  16'sh7FFF, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh7FFF, 1'b1,
          40'sd1073676289},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd63, 4'd15, 16'sh0000, 1'b1, 40'sd0},
        '{PLAN_WRITE,   CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_COLUMN_COUNT, 8'h00, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh1000, 1'b1,
          40'sd134213632},
        '{PLAN_WRITE,   CFG_INNER_LENGTH, 8'h82, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_COLUMN_COUNT, 8'hE2, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh2000, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_INNER_LENGTH, 8'h01, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'shE000, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_INNER_LENGTH, 8'h03, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_COLUMN_COUNT, 8'h01, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh7FFF, 1'b0, 40'sd0},
        '{PLAN_WRITE,   CFG_COLUMN_COUNT, 8'h10, REQ_LOAD,   6'd0,  4'd0,  16'sh0000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh8000, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_STREAM, 6'd0,  4'd0,  16'sh1234, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd63, 4'd15, 16'sh7FFF, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd63, 4'd0,  16'shFFFF, 1'b0, 40'sd0},
        '{PLAN_REQUEST, CFG_INNER_LENGTH, 8'h00, REQ_LOAD,   6'd0,  4'd15, 16'sh8000, 1'b0, 40'sd0}
    };

    matrix_multiply_stream_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_inner_index  (s_inner_index),
        .s_column_index (s_column_index),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_row      (m_out_row),
        .m_out_column   (m_out_column),
        .m_out_value    (m_out_value),
        .m_out_last     (m_out_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Row length as the block applies it: zero acts as one, large values saturate.
    function automatic int effective_inner();
        if (inner_len_copy == 0) return 1;
        if (inner_len_copy > DEF_MAX_INNER) return DEF_MAX_INNER;
        return int'(inner_len_copy);
    endfunction

    // Operands lean toward the extremes of Q4.12 now and then.
    function automatic logic signed [15:0] draw_operand();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one request, wait for its acceptance, then advance the shadow
    // model and queue the row results that it completes.
    task automatic issue_request(input logic kind, input logic [INNER_IDX_W-1:0] inner_idx,
                                 input logic [COL_IDX_W-1:0] col_idx,
                                 input logic signed [15:0] operand, input logic sum_given,
                                 input logic signed [ACC_W-1:0] given_sum);
        int gap;
        int n_eff;
        logic signed [31:0] product;
        row_result_t res;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_inner_index  <= inner_idx;
        s_column_index <= col_idx;
        s_value        <= operand;
        do @(posedge aclk); while (!s_ready);

        if (kind == REQ_LOAD) begin
            weight_copy[inner_idx][col_idx] = operand;
            return;
        end

        // Multiply-accumulate across the columns in use.
        if (col_count_copy == 0) n_eff = 1;
        else if (col_count_copy > DEF_MAX_COLUMNS) n_eff = DEF_MAX_COLUMNS;
        else n_eff = int'(col_count_copy);
        for (int c = 0; c < n_eff; c++) begin
            product = operand * weight_copy[position_copy][c];
            sum_copy[c] = sum_copy[c] + product;
        end

        // The element that reaches the row length closes the row.
        if (position_copy + 1 >= effective_inner()) begin
            for (int c = 0; c < n_eff; c++) begin
                res.out_row    = row_copy;
                res.out_column = COL_IDX_W'(c);
                res.out_value  = sum_given ? given_sum : sum_copy[c];
                res.out_last   = (c == n_eff - 1);
                pending_results.insert(pending_results.size(), res);
            end
            for (int c = 0; c < DEF_MAX_COLUMNS; c++) sum_copy[c] = '0;
            position_copy = 0;
            row_copy      = row_copy + 1'b1;
        end else begin
            position_copy++;
        end
    endtask

    // Register writes happen only with the block drained and settled.
    task automatic write_register(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == CFG_INNER_LENGTH) inner_len_copy = data[INNER_LEN_W-1:0];
        else col_count_copy = data[COL_CNT_W-1:0];
    endtask

    // Request source: reset, weight load of the first inner positions, the
    // directed table, then random phases.
    initial begin : stimulus
        int random_items;
        int phase;
        int k_eff;
        int rows;
        int len;
        logic [CFG_DATA_W-1:0] k_data;
        logic [CFG_DATA_W-1:0] n_data;
        plan_step_t step;

        random_items = 0;
        phase        = 0;
        for (int c = 0; c < DEF_MAX_COLUMNS; c++) sum_copy[c] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Every weight that a row can reach is written once, so no later read
        // hits an empty entry; rows never run past LOADED_INNER positions.
        for (int i = 0; i < LOADED_INNER; i++) begin
            for (int c = 0; c < DEF_MAX_COLUMNS; c++) begin
                issue_request(REQ_LOAD, INNER_IDX_W'(i), COL_IDX_W'(c), draw_operand(),
                              1'b0, '0);
            end
        end

        foreach (directed_plan[i]) begin
            step = directed_plan[i];
            if (step.op == PLAN_WRITE) begin
                write_register(step.reg_sel, step.reg_data);
            end else begin
                issue_request(step.req_type, step.inner_idx, step.col_idx, step.operand,
                              step.sum_given, step.given_sum);
            end
        end

        // Random phases: the first ones pin the column count extremes and a
        // row length whose top bit is dropped by the register.
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    k_data = 8'h84;
                    n_data = 8'h1F;
                end
                1: begin
                    k_data = 8'h01;
                    n_data = 8'h10;
                end
                2: begin
                    k_data = 8'h00;
                    n_data = 8'h00;
                end
                default: begin
                    k_data = {1'($urandom_range(0, 1)), 7'($urandom_range(0, LOADED_INNER))};
                    n_data = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                         : CFG_DATA_W'($urandom_range(1, 16));
                end
            endcase
            write_register(CFG_INNER_LENGTH, k_data);
            write_register(CFG_COLUMN_COUNT, n_data);
            steady_flow = ($urandom_range(0, 3) == 0);
            k_eff = effective_inner();
            rows  = (k_eff >= 16) ? 1 : $urandom_range(1, 5);
            for (int r = 0; r < rows; r++) begin
                len = k_eff;
                // Sometimes leave the last row open across the next register change.
                if (r == rows - 1 && k_eff > 1 && $urandom_range(0, 3) == 0) begin
                    len = $urandom_range(1, k_eff - 1);
                end
                for (int e = 0; e < len; e++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        issue_request(REQ_LOAD, INNER_IDX_W'($urandom_range(0, 63)),
                                      COL_IDX_W'($urandom_range(0, 15)), draw_operand(),
                                      1'b0, '0);
                        random_items++;
                    end
                    issue_request(REQ_STREAM, INNER_IDX_W'($urandom_range(0, 63)),
                                  COL_IDX_W'($urandom_range(0, 15)), draw_operand(), 1'b0, '0);
                    random_items++;
                end
            end
            phase++;
        end

        // Drain, then let the pipeline settle before the verdict.
        s_valid     <= 1'b0;
        steady_flow = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result sink: random back-pressure, and each result is compared with the
    // oldest queued expectation.
    initial begin : result_sink
        int stall;
        row_result_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                $error("unexpected result: row %0d column %0d value %0d",
                       m_out_row, m_out_column, m_out_value);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_out_row !== want.out_row) begin
                    $error("out_row mismatch: expected %0d, got %0d", want.out_row, m_out_row);
                    mismatch_count++;
                end
                if (m_out_column !== want.out_column) begin
                    $error("out_column mismatch: expected %0d, got %0d",
                           want.out_column, m_out_column);
                    mismatch_count++;
                end
                if (m_out_value !== want.out_value) begin
                    $error("out_value mismatch: expected %0d, got %0d",
                           want.out_value, m_out_value);
                    mismatch_count++;
                end
                if (m_out_last !== want.out_last) begin
                    $error("out_last mismatch: expected %0d, got %0d", want.out_last, m_out_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a long stretch with no accepted transfer on any channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
rtl/mms_pkg.sv
rtl/mms_ram.sv
rtl/mms_cell.sv
rtl/matrix_multiply_stream_top.sv
tb/tb_top.sv
